/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is held
`define GASP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen while out of reset
`define GASP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/gasp_pkg.sv */
package gasp_pkg;

    localparam int PAGE_WIDTH_DEF  = 256;
    localparam int PAGE_HEIGHT_DEF = 256;
    localparam int MAX_PAGES_DEF   = 16;

    localparam logic [7:0] ROW_HEIGHT_RST = 8'd16;

    // wide enough for page size plus two row heights and its power of two
    localparam int SZ_W = 14;

    typedef enum logic
    {
        OP_PLACE  = 1'b0,
        OP_FINISH = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t     opcode;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_width;
    } item_t;

    typedef struct packed
    {
        logic [8:0]  closed_page_height;
        logic [8:0]  closed_page_width;
        logic        closed_valid;
        logic [8:0]  lower_right_y;
        logic [8:0]  lower_right_x;
        logic [7:0]  upper_left_y;
        logic [7:0]  upper_left_x;
        logic [3:0]  page_index;
    } result_t;

    // smallest power of two not below v, one for zero
    function automatic logic [SZ_W-1:0] pow2_ceil(input logic [SZ_W-1:0] v);
        logic [SZ_W-1:0] m;
        m = v - SZ_W'(1);
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        if (v == '0)
        begin
            return SZ_W'(1);
        end
        return m + SZ_W'(1);
    endfunction

    // trimmed page edge: power of two capped at the page size, 9 bit field
    function automatic logic [8:0] trim_size(input logic [SZ_W-1:0] v,
                                             input logic [SZ_W-1:0] limit);
        logic [SZ_W-1:0] p;
        logic [SZ_W-1:0] r;
        p = pow2_ceil(v);
        r = (p < limit) ? p : limit;
        return r[8:0];
    endfunction

endpackage

/* hw/rtl/gasp_in_reg.sv */
module gasp_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  gasp_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output gasp_pkg::item_t item
);
    import gasp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free slot, or the held request leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/gasp_core.sv */
module gasp_core #(
    parameter int PAGE_WIDTH  = gasp_pkg::PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = gasp_pkg::PAGE_HEIGHT_DEF,
    parameter int MAX_PAGES   = gasp_pkg::MAX_PAGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        row_height,
    input  gasp_pkg::item_t   item,
    input  logic              advance,
    output gasp_pkg::result_t result
);
    import gasp_pkg::*;

    localparam int X_W  = $clog2(PAGE_WIDTH + 256);
    localparam int Y_W  = $clog2(PAGE_HEIGHT + 256);
    localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic [X_W-1:0]  pen_x_reg,    pen_x_next;
    logic [Y_W-1:0]  row_y_reg,    row_y_next;
    logic [X_W-1:0]  widest_x_reg, widest_x_next;
    logic [PG_W-1:0] page_reg,     page_next;

    logic            finish;
    logic [X_W:0]    pen_sum;
    logic            wrap;
    logic [X_W-1:0]  wide_max;
    logic [Y_W:0]    row_adv;
    logic [Y_W+1:0]  row_bot;
    logic            close;
    logic [Y_W+1:0]  h_src;
    logic            page_room;
    logic [X_W-1:0]  ul_x;
    logic [Y_W-1:0]  ul_y;
    logic [X_W:0]    lr_x;
    logic [Y_W:0]    lr_y;
    logic [8:0]      trim_w;
    logic [8:0]      trim_h;

    always_comb
    begin
        finish    = (item.opcode == OP_FINISH);
        pen_sum   = {1'b0, pen_x_reg} + (X_W+1)'(item.glyph_width);
        wrap      = !finish && (pen_sum >= (X_W+1)'(PAGE_WIDTH));
        wide_max  = (pen_x_reg > widest_x_reg) ? pen_x_reg : widest_x_reg;
        row_adv   = (Y_W+1)'(row_y_reg) + (Y_W+1)'(row_height);
        row_bot   = (Y_W+2)'(row_adv) + (Y_W+2)'(row_height);
        close     = wrap && (row_bot >= (Y_W+2)'(PAGE_HEIGHT));
        // finish sizes the page as it stands, a close sizes the row just opened
        h_src     = finish ? (Y_W+2)'(row_adv) : row_bot;
        page_room = (32'(page_reg) + 32'd1) < 32'(MAX_PAGES);
        trim_w    = trim_size(SZ_W'(wide_max), SZ_W'(PAGE_WIDTH));
        trim_h    = trim_size(SZ_W'(h_src), SZ_W'(PAGE_HEIGHT));

        pen_x_next    = pen_x_reg;
        row_y_next    = row_y_reg;
        widest_x_next = widest_x_reg;
        page_next     = page_reg;

        if (finish)
        begin
            widest_x_next = wide_max;
        end
        else if (close)
        begin
            widest_x_next = wide_max;
            pen_x_next    = X_W'(item.glyph_width);
            row_y_next    = '0;
            if (page_room)
            begin
                page_next = page_reg + PG_W'(1);
            end
        end
        else if (wrap)
        begin
            widest_x_next = wide_max;
            pen_x_next    = X_W'(item.glyph_width);
            row_y_next    = row_adv[Y_W-1:0];
        end
        else
        begin
            pen_x_next = pen_sum[X_W-1:0];
        end

        ul_x = wrap ? '0 : pen_x_reg;
        ul_y = close ? '0 : (wrap ? row_adv[Y_W-1:0] : row_y_reg);
        lr_x = wrap ? (X_W+1)'(item.glyph_width) : pen_sum;
        lr_y = (Y_W+1)'(ul_y) + (Y_W+1)'(item.glyph_height);

        result            = '0;
        result.page_index = 4'(page_next);
        if (finish)
        begin
            result.closed_valid       = 1'b1;
            result.closed_page_width  = trim_w;
            result.closed_page_height = trim_h;
        end
        else
        begin
            result.upper_left_x  = ul_x[7:0];
            result.upper_left_y  = ul_y[7:0];
            result.lower_right_x = lr_x[8:0];
            result.lower_right_y = lr_y[8:0];
            if (close)
            begin
                result.closed_valid       = 1'b1;
                result.closed_page_width  = trim_w;
                result.closed_page_height = trim_h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg    <= '0;
            row_y_reg    <= '0;
            widest_x_reg <= '0;
            page_reg     <= '0;
        end
        else if (advance)
        begin
            pen_x_reg    <= pen_x_next;
            row_y_reg    <= row_y_next;
            widest_x_reg <= widest_x_next;
            page_reg     <= page_next;
        end
    end

endmodule

/* hw/rtl/glyph_atlas_shelf_packer_top.sv */
// channel   dir  signals                           carries
// s_*       in   tvalid tready tdata[15:0] tuser   place or finish request
// m_*       out  tvalid tready tdata[55:0] tuser   placement and closed page size
// cfg_*     in   cfg_we cfg_wdata[7:0]             row height register write
//
// one request per cycle sustained while m_* is not stalled; a request passes from s_* to m_* through
// the input register, packing logic, then the result register feeding m_*
// the packing state advances when a request moves into the result register
// rst_n clears the packing state and sets the row height to 16
// a stalled m_* holds its result while one more request is buffered at s_*
`include "assert_macros.svh"

module glyph_atlas_shelf_packer_top #(
    parameter int PAGE_WIDTH  = gasp_pkg::PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = gasp_pkg::PAGE_HEIGHT_DEF,
    parameter int MAX_PAGES   = gasp_pkg::MAX_PAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // glyph_width[7:0], glyph_height[15:8]
    input  logic        s_tuser,   // opcode: 0 place, 1 finish

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // page_index[3:0], upper_left_x[11:4],
                                   // upper_left_y[19:12], lower_right_x[28:20],
                                   // lower_right_y[37:29], closed_page_width[46:38],
                                   // closed_page_height[55:47]
    output logic        m_tuser,   // closed_valid

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // row_height
);
    import gasp_pkg::*;

    logic       row_height_reg;
    logic [7:0] row_h_reg;

    item_t      s_item;
    item_t      item;
    logic       item_valid;
    logic       advance;
    result_t    result;

    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    // row height register, to be written only while the packer is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_h_reg <= ROW_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            row_h_reg <= cfg_wdata;
        end
    end

    // marks a row height set since reset, used by the check below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_height_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            row_height_reg <= 1'b1;
        end
    end

    always_comb
    begin
        s_item              = '0;
        s_item.opcode       = opcode_t'(s_tuser);
        s_item.glyph_width  = s_tdata[7:0];
        s_item.glyph_height = s_tdata[15:8];
    end

    // a buffered request moves on when the result register is free or drains
    assign advance = item_valid && (!out_valid_reg || m_tready);

    gasp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    gasp_core #(
        .PAGE_WIDTH  (PAGE_WIDTH),
        .PAGE_HEIGHT (PAGE_HEIGHT),
        .MAX_PAGES   (MAX_PAGES)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_height (row_h_reg),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

    // result register
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.closed_valid;
    assign m_tdata  = {out_reg.closed_page_height, out_reg.closed_page_width,
                       out_reg.lower_right_y, out_reg.lower_right_x,
                       out_reg.upper_left_y, out_reg.upper_left_x,
                       out_reg.page_index};

    // a closed page or a finish always reports its upper left corner as zero
    `GASP_ASSERT(a_closed_no_corner, clk, rst_n,
        (m_tvalid && m_tuser) |-> (out_reg.upper_left_x == 8'd0 && out_reg.upper_left_y == 8'd0),
        "closed result with nonzero upper left corner")

    // a plain placement reports no page size
    `GASP_ASSERT(a_open_no_size, clk, rst_n,
        (m_tvalid && !m_tuser) |-> (m_tdata[55:38] == 18'd0),
        "placement result with a page size")

    // input side only stalls with both registers full
    `GASP_NEVER(a_stall_cause, clk, rst_n,
        !s_tready && !(item_valid && out_valid_reg && !m_tready),
        "input stalled with room in the pipeline")

    // row height stays at its reset value until first written
    `GASP_ASSERT(a_row_h_reset, clk, rst_n,
        !row_height_reg |-> (row_h_reg == ROW_HEIGHT_RST),
        "row height changed without a write")

endmodule

/* tb/sv/glyph_atlas_shelf_packer_checker.sv */
module glyph_atlas_shelf_packer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int          failures,
    output int          results_seen,
    output int          left_waiting,
    output int          pages_closed,
    output int          last_page
);
    import gasp_pkg::*;

    localparam int PAGE_W = PAGE_WIDTH_DEF;
    localparam int PAGE_H = PAGE_HEIGHT_DEF;
    localparam int PAGES  = MAX_PAGES_DEF;

    logic [7:0] row_height;
    logic [8:0] pen_x;
    logic [8:0] row_y;
    logic [8:0] widest_x;
    logic [3:0] page;

    result_t placements[$];
    int      n_fail;
    int      n_seen;
    int      n_closed;

    // power of two not below v, capped at the page edge
    function automatic logic [8:0] shrink_edge(input int unsigned v, input int unsigned lim);
        int unsigned p;
        p = 1;
        while (p < v)
        begin
            p = p << 1;
        end
        if (p > lim)
        begin
            p = lim;
        end
        return p[8:0];
    endfunction

    // advances the shelf state by one request and returns its expected result
    function automatic result_t place_glyph(input opcode_t op, input logic [7:0] w,
                                            input logic [7:0] h);
        result_t r;
        r = '0;
        if (op == OP_FINISH)
        begin
            if (pen_x > widest_x)
            begin
                widest_x = pen_x;
            end
            r.page_index         = page;
            r.closed_valid       = 1'b1;
            r.closed_page_width  = shrink_edge(32'(widest_x), PAGE_W);
            r.closed_page_height = shrink_edge(32'(row_y) + 32'(row_height), PAGE_H);
            return r;
        end
        if (pen_x + w >= PAGE_W)
        begin
            if (pen_x > widest_x)
            begin
                widest_x = pen_x;
            end
            pen_x = '0;
            row_y = row_y + row_height;
            if (row_y + row_height >= PAGE_H)
            begin
                r.closed_valid       = 1'b1;
                r.closed_page_width  = shrink_edge(32'(widest_x), PAGE_W);
                r.closed_page_height = shrink_edge(32'(row_y) + 32'(row_height), PAGE_H);
                row_y = '0;
                n_closed++;
                if (page + 1 < PAGES)
                begin
                    page = page + 1'b1;
                end
            end
        end
        r.page_index    = page;
        r.upper_left_x  = pen_x[7:0];
        r.upper_left_y  = row_y[7:0];
        r.lower_right_x = pen_x + w;
        r.lower_right_y = row_y + h;
        pen_x = pen_x + w;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            n_fail++;
            if (n_fail <= 40)
            begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            row_height = ROW_HEIGHT_RST;
            pen_x      = '0;
            row_y      = '0;
            widest_x   = '0;
            page       = '0;
            placements.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.page_index         = m_tdata[3:0];
                got.upper_left_x       = m_tdata[11:4];
                got.upper_left_y       = m_tdata[19:12];
                got.lower_right_x      = m_tdata[28:20];
                got.lower_right_y      = m_tdata[37:29];
                got.closed_page_width  = m_tdata[46:38];
                got.closed_page_height = m_tdata[55:47];
                got.closed_valid       = m_tuser;
                n_seen++;
                if (placements.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 40)
                    begin
                        $display("%0t mismatch: expected no result, actual tdata %h tuser %b",
                                 $time, m_tdata, m_tuser);
                    end
                end
                else
                begin
                    want = placements.pop_front();
                    check_field("page_index", 32'(want.page_index), 32'(got.page_index));
                    check_field("upper_left_x", 32'(want.upper_left_x),
                                32'(got.upper_left_x));
                    check_field("upper_left_y", 32'(want.upper_left_y),
                                32'(got.upper_left_y));
                    check_field("lower_right_x", 32'(want.lower_right_x),
                                32'(got.lower_right_x));
                    check_field("lower_right_y", 32'(want.lower_right_y),
                                32'(got.lower_right_y));
                    check_field("closed_valid", 32'(want.closed_valid),
                                32'(got.closed_valid));
                    check_field("closed_page_width", 32'(want.closed_page_width),
                                32'(got.closed_page_width));
                    check_field("closed_page_height", 32'(want.closed_page_height),
                                32'(got.closed_page_height));
                end
            end
            if (s_tvalid && s_tready)
            begin
                placements.insert(placements.size(),
                                  place_glyph(opcode_t'(s_tuser), s_tdata[7:0],
                                              s_tdata[15:8]));
            end
            if (cfg_we)
            begin
                row_height = cfg_wdata;
            end
        end
        failures     <= n_fail;
        results_seen <= n_seen;
        left_waiting <= placements.size();
        pages_closed <= n_closed;
        last_page    <= int'(page);
    end

endmodule

/* tb/sv/glyph_atlas_shelf_packer_top_test.sv */
module glyph_atlas_shelf_packer_top_test;

    import gasp_pkg::*;

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;   // glyph_width[7:0], glyph_height[15:8]
    logic        s_tuser   = 1'b0; // opcode
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;   // row_height

    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;
    logic        m_tuser;

    // checker results
    int mism;
    int results;
    int waiting;
    int closes;
    int last_page;

    // stimulus bookkeeping
    int   sent       = 0;
    int   settings   = 0;
    int   stall_left = 0;
    logic smooth     = 1'b0;   // no idling on either side while set

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    glyph_atlas_shelf_packer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    glyph_atlas_shelf_packer_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .failures     (mism),
        .results_seen (results),
        .left_waiting (waiting),
        .pages_closed (closes),
        .last_page    (last_page)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // result side backpressure, stalls of random length
    always @(posedge clk)
    begin
        if (stall_left == 0 && !smooth)
        begin
            stall_left = pick_gap();
        end
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // one request, optionally after an idle gap; returns at its accept edge
    // with tvalid still high so back-to-back requests leave no gap between them
    task automatic send(input opcode_t op, input logic [7:0] w, input logic [7:0] h);
        int gap;
        gap = smooth ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h, w};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // stop requesting and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results != sent)
        begin
            @(posedge clk);
        end
        // two stage pipe, let it sit idle before touching the register
        repeat (4) @(posedge clk);
    endtask

    // row height register write, only with the block idle
    task automatic set_row_height(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // random requests: mixes of narrow and wide glyphs so rows fill and pages
    // close, with an occasional finish
    task automatic random_phase(input int count);
        int      roll;
        opcode_t op;
        logic [7:0] w;
        logic [7:0] h;
        for (int i = 0; i < count; i++)
        begin
            if (i % 80 == 0)
            begin
                smooth <= ($urandom_range(0, 3) == 0);
            end
            op   = ($urandom_range(0, 99) < 8) ? OP_FINISH : OP_PLACE;
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                w = 8'($urandom_range(0, 31));
            end
            else if (roll < 70)
            begin
                w = 8'($urandom_range(128, 255));
            end
            else
            begin
                w = 8'($urandom_range(0, 255));
            end
            h = 8'($urandom_range(0, 255));
            send(op, w, h);
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset row height of 16: finish on an empty page reports the
        // smallest size, then rows that end exactly at the page edge
        send(OP_FINISH, 8'd0, 8'd0);
        send(OP_PLACE, 8'd0, 8'd0);
        send(OP_PLACE, 8'd255, 8'd255);
        send(OP_PLACE, 8'd1, 8'd0);
        send(OP_PLACE, 8'd255, 8'd0);
        send(OP_PLACE, 8'haa, 8'h55);
        // finish folds the pen into the widest x and leaves the page open
        send(OP_FINISH, 8'd0, 8'd0);

        // tallest rows: every new row closes the page, enough of them to
        // run the page index into saturation; widest x carries over pages
        set_row_height(8'd255);
        send(OP_PLACE, 8'd255, 8'd255);
        for (int i = 0; i < 17; i++)
        begin
            send(OP_PLACE, 8'd200, 8'($urandom_range(0, 255)));
        end
        send(OP_FINISH, 8'hff, 8'hff);

        // zero row height first: rows never advance and pages never close
        set_row_height(8'd0);
        random_phase(250);
        set_row_height(8'd1);
        random_phase(250);
        set_row_height(8'd255);
        random_phase(250);
        set_row_height(8'($urandom_range(1, 255)));
        random_phase(250);
        set_row_height(8'($urandom_range(2, 48)));
        random_phase(250);
        set_row_height(8'd16);
        random_phase(250);

        drain();
        repeat (8) @(posedge clk);

        $display("tb: %0d requests under %0d row height settings, %0d results compared",
                 sent, settings + 1, results);
        $display("tb: %0d pages closed by placement, final page index %0d",
                 closes, last_page);
        if (mism == 0 && waiting == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/gasp_pkg.sv
hw/rtl/gasp_in_reg.sv
hw/rtl/gasp_core.sv
hw/rtl/glyph_atlas_shelf_packer_top.sv
tb/sv/glyph_atlas_shelf_packer_checker.sv
tb/sv/glyph_atlas_shelf_packer_top_test.sv
